### rtl/acws_pkg.sv
`default_nettype none

package acws_pkg;

   // Field widths
   localparam int SAMPLE_W     = 24;
   localparam int CHANNEL_W    = 3;
   localparam int MAG_W        = 24;
   localparam int SQ_W         = 47;
   localparam int FRAME_W      = 17;
   localparam int CH_COUNT_W   = 4;
   localparam int SUM_W        = 64;
   localparam int MS_W         = 47;
   localparam int COUNT_W      = 48;
   localparam int WIN_COUNT_W  = 32;
   localparam int DIVISOR_W    = 20;
   localparam int DIV_STEP_W   = 6;
   localparam int MAX_CHANNELS = 8;

   // Port widths
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 304;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 47;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW_SIZE       = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CHANNEL_COUNT     = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_NEAR_FULL_LEVEL   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_CLIP_LEVEL        = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_PLATEAU_TOLERANCE = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_ACTIVE_LEVEL_SQ   = 3'd5;

   // Register reset values
   localparam logic [FRAME_W-1:0]    RST_WINDOW_SIZE       = 17'd2048;
   localparam logic [CH_COUNT_W-1:0] RST_CHANNEL_COUNT     = 4'd2;
   localparam logic [MAG_W-1:0]      RST_NEAR_FULL_LEVEL   = 24'd8262779;
   localparam logic [MAG_W-1:0]      RST_CLIP_LEVEL        = 24'd8387769;
   localparam logic [MAG_W-1:0]      RST_PLATEAU_TOLERANCE = 24'd168;
   localparam logic [MS_W-1:0]       RST_ACTIVE_LEVEL_SQ   = 47'd7037;

   // Input item mode
   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_FLUSH  = 1'b1;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic mag_en;
      logic upd_en;
      logic acc_en;
      logic div_start;
      logic fin_en;
      logic load_en;
   } acws_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic flush;
      logic frames_zero;
      logic close_now;
      logic out_busy;
   } acws_status_type;

endpackage

`default_nettype wire

### rtl/acws_div.sv
`default_nettype none

module acws_div (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            start,
   input  wire [acws_pkg::SUM_W-1:0]      dividend,
   input  wire [acws_pkg::DIVISOR_W-1:0]  divisor,
   output logic                           busy,
   output logic                           done,
   output logic [acws_pkg::SUM_W-1:0]     quotient
);
   import acws_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]      quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVISOR_W:0]    rem_sh;
   logic [DIVISOR_W:0]    rem_diff;

   // One quotient bit per cycle, restoring
   assign rem_sh   = {rem_ff, quo_ff[SUM_W-1]};
   assign rem_diff = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!rem_diff[DIVISOR_W]) begin
            rem_in = rem_diff[DIVISOR_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DIVISOR_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (&step_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

### rtl/acws_ctrl.sv
`default_nettype none

module acws_ctrl (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   input  wire acws_pkg::acws_status_type status,
   input  wire                        div_done,
   output acws_pkg::acws_cmd_type     cmd
);
   import acws_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MAG  = 3'd1;
   localparam logic [2:0] ST_UPD  = 3'd2;
   localparam logic [2:0] ST_ACC  = 3'd3;
   localparam logic [2:0] ST_PREP = 3'd4;
   localparam logic [2:0] ST_DIV  = 3'd5;
   localparam logic [2:0] ST_FIN  = 3'd6;
   localparam logic [2:0] ST_LOAD = 3'd7;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MAG;
            end
         end
         ST_MAG: begin
            if (status.flush) begin
               state_in = status.frames_zero ? ST_IDLE : ST_PREP;
            end else begin
               cmd.mag_en = 1'b1;
               state_in   = ST_UPD;
            end
         end
         ST_UPD: begin
            cmd.upd_en = 1'b1;
            state_in   = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_en = 1'b1;
            state_in   = status.close_now ? ST_PREP : ST_IDLE;
         end
         ST_PREP: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.fin_en = 1'b1;
            state_in   = ST_LOAD;
         end
         ST_LOAD: begin
            if (!status.out_busy) begin
               cmd.load_en = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

`default_nettype wire

### rtl/acws_datapath.sv
`default_nettype none

module acws_datapath (
   input  wire                              clock,
   input  wire                              reset,
   input  wire acws_pkg::acws_cmd_type      cmd,
   output acws_pkg::acws_status_type        status,
   input  wire                              req_tuser,
   input  wire [acws_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [acws_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  wire                              csr_we,
   input  wire [acws_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire [acws_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic [acws_pkg::SUM_W-1:0]       div_dividend,
   output logic [acws_pkg::DIVISOR_W-1:0]   div_divisor,
   input  wire [acws_pkg::SUM_W-1:0]        div_quotient
);
   import acws_pkg::*;

   function automatic logic [COUNT_W-1:0] sat_inc_count(input logic [COUNT_W-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [WIN_COUNT_W-1:0] sat_inc_win(input logic [WIN_COUNT_W-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   // Configuration
   logic [FRAME_W-1:0]    win_len_ff;
   logic [CH_COUNT_W-1:0] channel_count_ff;
   logic [MAG_W-1:0]      nf_level_ff;
   logic [MAG_W-1:0]      clip_level_ff;
   logic [MAG_W-1:0]      plateau_tol_ff;
   logic [MS_W-1:0]       active_level_ff;

   // Captured item and stage registers
   logic                  mode_ff;
   logic [SAMPLE_W-1:0]   sample_ff;
   logic [CHANNEL_W-1:0]  channel_ff;
   logic [MAG_W-1:0]      mag_ff;
   logic [SQ_W-1:0]       sq_ff;
   logic                  frame_end_ff;

   // History and window state
   logic [MAG_W-1:0]      prev_mag_ff [MAX_CHANNELS];
   logic                  prev_nf_ff  [MAX_CHANNELS];
   logic [SUM_W-1:0]      sum_ff;
   logic [MAG_W-1:0]      peak_ff;
   logic [FRAME_W-1:0]    frames_ff;
   logic                  clip_ff;

   // Running totals
   logic [COUNT_W-1:0]     near_total_ff;
   logic [COUNT_W-1:0]     plateau_total_ff;
   logic [COUNT_W-1:0]     sample_total_ff;
   logic [WIN_COUNT_W-1:0] active_total_ff;
   logic [WIN_COUNT_W-1:0] clipped_total_ff;

   // Close results
   logic [MS_W-1:0]       ms_ff;
   logic                  active_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [CH_COUNT_W-1:0] eff_ch;
   logic [CH_COUNT_W-1:0] eff_last;
   logic [MAG_W-1:0]      mag_abs;
   logic                  nf_hit;
   logic [MAG_W-1:0]      prev_mag;
   logic [MAG_W-1:0]      mag_diff;
   logic                  plateau;
   logic [2*MAG_W-1:0]    sq_full;
   logic [SUM_W:0]        sum_add;
   logic [FRAME_W-1:0]    frames_inc;
   logic [FRAME_W-1:0]    limit;
   logic [DIVISOR_W:0]    divisor_full;
   logic [MS_W-1:0]       ms_sat;
   logic                  active_now;

   // Clamp the channel count to 1..MAX_CHANNELS
   always_comb begin
      if (channel_count_ff == '0)
         eff_ch = CH_COUNT_W'(1);
      else if (channel_count_ff > CH_COUNT_W'(MAX_CHANNELS))
         eff_ch = CH_COUNT_W'(MAX_CHANNELS);
      else
         eff_ch = channel_count_ff;
   end
   assign eff_last = eff_ch - 1'b1;

   assign mag_abs  = sample_ff[SAMPLE_W-1] ? (~sample_ff + 1'b1) : sample_ff;

   assign nf_hit    = (mag_ff >= nf_level_ff);
   assign prev_mag  = prev_mag_ff[channel_ff];
   assign mag_diff  = (mag_ff >= prev_mag) ? (mag_ff - prev_mag) : (prev_mag - mag_ff);
   assign plateau   = nf_hit && prev_nf_ff[channel_ff] && (mag_diff <= plateau_tol_ff);
   assign sq_full   = mag_ff * mag_ff;

   assign sum_add    = {1'b0, sum_ff} + (SUM_W+1)'(sq_ff);
   assign frames_inc = (&frames_ff) ? frames_ff : frames_ff + 1'b1;
   assign limit      = (win_len_ff == '0) ? FRAME_W'(1) : win_len_ff;

   assign divisor_full = (DIVISOR_W+1)'(frames_ff) * (DIVISOR_W+1)'(eff_ch);
   assign div_divisor  = divisor_full[DIVISOR_W-1:0];
   assign div_dividend = sum_ff;

   assign ms_sat     = (|div_quotient[SUM_W-1:MS_W]) ? '1 : div_quotient[MS_W-1:0];
   assign active_now = (ms_sat > active_level_ff);

   assign status.flush       = (mode_ff == MODE_FLUSH);
   assign status.frames_zero = (frames_ff == '0);
   assign status.close_now   = frame_end_ff && (frames_inc >= limit);
   assign status.out_busy    = rsp_valid_ff && !rsp_tready;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         win_len_ff         <= RST_WINDOW_SIZE;
         channel_count_ff   <= RST_CHANNEL_COUNT;
         nf_level_ff        <= RST_NEAR_FULL_LEVEL;
         clip_level_ff      <= RST_CLIP_LEVEL;
         plateau_tol_ff     <= RST_PLATEAU_TOLERANCE;
         active_level_ff    <= RST_ACTIVE_LEVEL_SQ;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_WINDOW_SIZE:       win_len_ff         <= csr_wdata[FRAME_W-1:0];
            CSR_CHANNEL_COUNT:     channel_count_ff   <= csr_wdata[CH_COUNT_W-1:0];
            CSR_NEAR_FULL_LEVEL:   nf_level_ff        <= csr_wdata[MAG_W-1:0];
            CSR_CLIP_LEVEL:        clip_level_ff      <= csr_wdata[MAG_W-1:0];
            CSR_PLATEAU_TOLERANCE: plateau_tol_ff     <= csr_wdata[MAG_W-1:0];
            CSR_ACTIVE_LEVEL_SQ:   active_level_ff    <= csr_wdata[MS_W-1:0];
            default: ;
         endcase
      end
   end

   // Item capture and per-sample stages
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff    <= req_tuser;
         sample_ff  <= req_tdata[SAMPLE_W-1:0];
         channel_ff <= req_tdata[SAMPLE_W +: CHANNEL_W];
      end
      if (cmd.mag_en) mag_ff <= mag_abs;
      if (cmd.upd_en) begin
         sq_ff        <= sq_full[SQ_W-1:0];
         frame_end_ff <= ({1'b0, channel_ff} == eff_last);
         prev_mag_ff[channel_ff] <= mag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CHANNELS; i++) prev_nf_ff[i] <= 1'b0;
         sum_ff           <= '0;
         peak_ff          <= '0;
         frames_ff        <= '0;
         clip_ff          <= 1'b0;
         near_total_ff    <= '0;
         plateau_total_ff <= '0;
         sample_total_ff  <= '0;
         active_total_ff  <= '0;
         clipped_total_ff <= '0;
      end else begin
         if (cmd.upd_en) begin
            prev_nf_ff[channel_ff] <= nf_hit;
            if (nf_hit) near_total_ff <= sat_inc_count(near_total_ff);
            if (plateau) plateau_total_ff <= sat_inc_count(plateau_total_ff);
            sample_total_ff <= sat_inc_count(sample_total_ff);
            if (mag_ff >= clip_level_ff) clip_ff <= 1'b1;
            if (mag_ff > peak_ff) peak_ff <= mag_ff;
         end
         if (cmd.acc_en) begin
            // Saturate the square sum at all ones
            sum_ff <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
            if (frame_end_ff) frames_ff <= frames_inc;
         end
         if (cmd.fin_en && active_now) begin
            active_total_ff <= sat_inc_win(active_total_ff);
            if (clip_ff) clipped_total_ff <= sat_inc_win(clipped_total_ff);
         end
         if (cmd.load_en) begin
            sum_ff    <= '0;
            peak_ff   <= '0;
            frames_ff <= '0;
            clip_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fin_en) begin
         ms_ff     <= ms_sat;
         active_ff <= active_now;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_en)     rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
      if (cmd.load_en) begin
         rsp_data_ff <= {6'b0, clipped_total_ff, active_total_ff, sample_total_ff,
                         plateau_total_ff, near_total_ff, clip_ff, active_ff,
                         frames_ff, peak_ff, ms_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

### rtl/audio_clip_window_stats_core.sv
`default_nettype none

// Window statistics and clip detector for interleaved signed 24-bit audio.
// Send one sample per item (req_tuser low) with its channel index; a frame
// ends on the sample whose channel is the clamped channel count minus one.
// Each sample updates the near-full, plateau and sample counters, the
// window peak, clip flag and square sum. When the frame count reaches
// the window size, or on a flush item (req_tuser high) with at least one
// complete frame, the window closes and one result item carries the
// truncated mean square, peak, frame count, active and clip flags and the
// running counters. A flush with no complete frame yields nothing.
// Sequence: a sample item passes through capture, magnitude, square and
// history update, and accumulate. A closing item adds divisor setup, the
// bit-serial divider (one quotient bit per cycle over the 64-bit square
// sum, then its registered done flag), the threshold check and the result
// load. If the previous result is still waiting at the output, the load
// holds until it is taken; new items are accepted meanwhile only once the
// close is done. Configuration writes take effect at once and belong in
// idle periods.

module audio_clip_window_stats_core (
   input  wire                              clock,
   input  wire                              reset,
   // Input items
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire [acws_pkg::REQ_DATA_W-1:0]   req_tdata,  // sample[23:0], channel[26:24]
   input  wire                              req_tuser,  // mode: 0 sample, 1 flush
   // Result items
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // mean square[46:0], peak[70:47], frames[87:71],
   // active flag[88], clip flag[89], near-full count[137:90],
   // plateau count[185:138], sample count[233:186],
   // active window count[265:234], clipped window count[297:266]
   output logic [acws_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // Configuration writes
   input  wire                              csr_we,
   input  wire [acws_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire [acws_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import acws_pkg::*;

   acws_cmd_type          cmd;
   acws_status_type       status;
   logic                  div_busy;
   logic                  div_done;
   logic [SUM_W-1:0]      div_dividend;
   logic [DIVISOR_W-1:0]  div_divisor;
   logic [SUM_W-1:0]      div_quotient;

   // Sequence each item through the datapath
   acws_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .div_done   (div_done),
      .cmd        (cmd)
   );

   // Hold configuration, history, window state, totals and the result register
   acws_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_tuser    (req_tuser),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_quotient (div_quotient)
   );

   // Mean square divider: square sum over frames times channels
   acws_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

`ifndef SYNTHESIS
   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.load_en |-> (!rsp_tvalid || rsp_tready))
      else $error("result loaded over a pending result");

   a_no_accept_while_dividing: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_busy)
      else $error("input ready while the divider runs");

   a_start_runs_divider: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> (div_busy && !req_tready))
      else $error("divider not running after start");
`endif

endmodule

`default_nettype wire

### tb/sv/audio_clip_window_stats_core_test.sv
`timescale 1ns / 100ps

module audio_clip_window_stats_core_test;
   import acws_pkg::*;

   // Run sizing
   localparam int RANDOM_PHASES = 10;
   localparam int ITEMS_PER_PHASE = 80;
   // An item that closes a window runs through the divider; leave margin
   // before touching registers
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT = 600000;
   localparam int REPORT_LIMIT = 100;
   localparam logic [MS_W-1:0] MS_MAX = 47'h7FFF_FFFF_FFFF;
   localparam int FULL_SCALE = 8388608;

   // One input item: sample or flush
   typedef struct packed {
      logic mode;
      logic [CHANNEL_W-1:0] channel;
      logic [SAMPLE_W-1:0] sample;
   } audio_item_type;

   // One window report, laid out as on rsp_tdata (lowest field last)
   typedef struct packed {
      logic [WIN_COUNT_W-1:0] clipped_count;
      logic [WIN_COUNT_W-1:0] active_count;
      logic [COUNT_W-1:0] sample_count;
      logic [COUNT_W-1:0] plateau_count;
      logic [COUNT_W-1:0] near_full_count;
      logic clip_seen;
      logic window_active;
      logic [FRAME_W-1:0] window_frames;
      logic [MAG_W-1:0] peak_mag;
      logic [MS_W-1:0] window_mean_square;
   } window_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   wire req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   wire rsp_tvalid;
   logic rsp_tready = 1'b0;
   wire [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   audio_clip_window_stats_core uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   // Register image as last written
   logic [FRAME_W-1:0] cfg_win_len = RST_WINDOW_SIZE;
   logic [CH_COUNT_W-1:0] cfg_channels = RST_CHANNEL_COUNT;
   logic [MAG_W-1:0] cfg_nf_level = RST_NEAR_FULL_LEVEL;
   logic [MAG_W-1:0] cfg_clip = RST_CLIP_LEVEL;
   logic [MAG_W-1:0] cfg_tolerance = RST_PLATEAU_TOLERANCE;
   logic [MS_W-1:0] cfg_active_sq = RST_ACTIVE_LEVEL_SQ;

   // Window statistics state, advanced on every accepted item
   logic [MAG_W-1:0] hist_mag [MAX_CHANNELS];
   logic hist_near [MAX_CHANNELS];
   logic [SUM_W-1:0] win_sum = '0;
   logic [MAG_W-1:0] win_peak = '0;
   logic [FRAME_W-1:0] win_frames = '0;
   logic win_clip = 1'b0;
   logic [COUNT_W-1:0] near_total = '0;
   logic [COUNT_W-1:0] plateau_total = '0;
   logic [COUNT_W-1:0] sample_total = '0;
   logic [WIN_COUNT_W-1:0] active_total = '0;
   logic [WIN_COUNT_W-1:0] clipped_total = '0;

   // Items waiting to be sent, and reports waiting to arrive
   audio_item_type sample_backlog [$];
   window_report_type pending_reports [$];

   audio_item_type cur_item;
   int last_mag [MAX_CHANNELS];
   int send_gap = 0;
   int recv_gap = 0;
   bit idle_on = 1'b1;
   int items_queued = 0;
   int items_accepted = 0;
   int flushes_queued = 0;
   int reports_checked = 0;
   int settings_used = 0;
   int fail_count = 0;
   int cycle_count = 0;

   // Free-running clock, 8 ns period
   initial begin
      forever #4 clock = ~clock;
   end

   // Channel count as the block uses it: zero acts as one, above the max
   // acts as the max. It is also the channel factor of the divisor.
   function automatic logic [CH_COUNT_W-1:0] active_channels();
      if (cfg_channels == 4'd0) return 4'd1;
      if (cfg_channels > 4'(MAX_CHANNELS)) return 4'(MAX_CHANNELS);
      return cfg_channels;
   endfunction

   // Close the window: divide, check the threshold, queue the report, clear
   task automatic emit_report();
      logic [SUM_W-1:0] divisor;
      logic [SUM_W-1:0] mean_sq;
      logic is_active;
      window_report_type rpt;
      // Flush with no complete frame: nothing happens at all
      if (win_frames == '0) return;
      divisor = {47'd0, win_frames} * {60'd0, active_channels()};
      mean_sq = win_sum / divisor;
      if (mean_sq > {17'd0, MS_MAX}) mean_sq = {17'd0, MS_MAX};
      is_active = mean_sq > {17'd0, cfg_active_sq};
      if (is_active) begin
         if (~&active_total) active_total = active_total + 32'd1;
         if (win_clip && ~&clipped_total) clipped_total = clipped_total + 32'd1;
      end
      rpt.window_mean_square = mean_sq[MS_W-1:0];
      rpt.peak_mag = win_peak;
      rpt.window_frames = win_frames;
      rpt.window_active = is_active;
      rpt.clip_seen = win_clip;
      rpt.near_full_count = near_total;
      rpt.plateau_count = plateau_total;
      rpt.sample_count = sample_total;
      rpt.active_count = active_total;
      rpt.clipped_count = clipped_total;
      pending_reports.insert(pending_reports.size(), rpt);
      win_sum = '0;
      win_peak = '0;
      win_frames = '0;
      win_clip = 1'b0;
   endtask

   // Advance the window statistics by one accepted item
   task automatic update_window_stats(input audio_item_type it);
      logic [MAG_W:0] mag_wide;
      logic [MAG_W-1:0] mag;
      logic [MAG_W-1:0] diff;
      logic [SUM_W-1:0] sq;
      logic [SUM_W:0] sum_wide;
      logic [FRAME_W-1:0] limit;
      logic near;
      if (it.mode == MODE_FLUSH) begin
         emit_report();
         return;
      end
      // Magnitude of two's complement; the most negative value gives 2^23
      if (it.sample[SAMPLE_W-1]) mag_wide = 25'h100_0000 - {1'b0, it.sample};
      else mag_wide = {1'b0, it.sample};
      mag = mag_wide[MAG_W-1:0];
      near = mag >= cfg_nf_level;
      // Channel is 3 bits wide, so every sample has a history entry
      if (near) begin
         if (~&near_total) near_total = near_total + 48'd1;
         if (hist_near[it.channel]) begin
            if (mag >= hist_mag[it.channel]) diff = mag - hist_mag[it.channel];
            else diff = hist_mag[it.channel] - mag;
            if (diff <= cfg_tolerance && ~&plateau_total)
               plateau_total = plateau_total + 48'd1;
         end
      end
      if (mag >= cfg_clip) win_clip = 1'b1;
      hist_mag[it.channel] = mag;
      hist_near[it.channel] = near;
      if (~&sample_total) sample_total = sample_total + 48'd1;
      sq = {40'd0, mag} * {40'd0, mag};
      sum_wide = {1'b0, win_sum} + {1'b0, sq};
      win_sum = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
      if (mag > win_peak) win_peak = mag;
      // Only the highest channel ends a frame; stray channels never do
      if ({1'b0, it.channel} == active_channels() - 4'd1) begin
         if (win_frames != 17'h1FFFF) win_frames = win_frames + 17'd1;
         limit = (cfg_win_len == '0) ? 17'd1 : cfg_win_len;
         if (win_frames >= limit) emit_report();
      end
   endtask

   // Write all six registers back to back, then drop the enable
   task automatic write_settings(input logic [FRAME_W-1:0] ws,
                                 input logic [CH_COUNT_W-1:0] cc,
                                 input logic [MAG_W-1:0] nf,
                                 input logic [MAG_W-1:0] clip,
                                 input logic [MAG_W-1:0] tol,
                                 input logic [MS_W-1:0] act);
      logic [CSR_ADDR_W-1:0] addr;
      logic [CSR_DATA_W-1:0] value;
      for (int i = 0; i < 6; i++) begin
         case (i)
            0: begin addr = CSR_WINDOW_SIZE; value = {30'd0, ws}; end
            1: begin addr = CSR_CHANNEL_COUNT; value = {43'd0, cc}; end
            2: begin addr = CSR_NEAR_FULL_LEVEL; value = {23'd0, nf}; end
            3: begin addr = CSR_CLIP_LEVEL; value = {23'd0, clip}; end
            4: begin addr = CSR_PLATEAU_TOLERANCE; value = {23'd0, tol}; end
            default: begin addr = CSR_ACTIVE_LEVEL_SQ; value = act; end
         endcase
         @(posedge clock);
         csr_we <= 1'b1;
         csr_addr <= addr;
         csr_wdata <= value;
      end
      cfg_win_len = ws;
      cfg_channels = cc;
      cfg_nf_level = nf;
      cfg_clip = clip;
      cfg_tolerance = tol;
      cfg_active_sq = act;
      settings_used++;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic push_item(input logic mode, input logic [SAMPLE_W-1:0] smp,
                            input logic [CHANNEL_W-1:0] ch);
      audio_item_type it;
      it.mode = mode;
      it.sample = smp;
      it.channel = ch;
      sample_backlog.insert(sample_backlog.size(), it);
      items_queued++;
      if (mode == MODE_FLUSH) flushes_queued++;
   endtask

   // Pick a sample for a channel: full scale, near the near-full level,
   // close to the channel's last magnitude (plateau bait), small, or raw
   task automatic make_sample(input logic [CHANNEL_W-1:0] ch,
                              output logic [SAMPLE_W-1:0] smp);
      int m;
      bit raw_pick;
      logic [31:0] r;
      logic [MAG_W:0] neg_wide;
      r = $urandom;
      raw_pick = 1'b0;
      m = 0;
      case ($urandom_range(0, 9))
         0: m = FULL_SCALE;
         1: m = FULL_SCALE - 1;
         2, 3: m = int'(cfg_nf_level) + int'($urandom_range(0, 400));
         4, 5: m = last_mag[ch] + int'($urandom_range(0, 400)) - 200;
         6: m = int'($urandom_range(0, 255));
         default: raw_pick = 1'b1;
      endcase
      if (raw_pick) begin
         smp = r[SAMPLE_W-1:0];
      end else begin
         if (m < 0) m = 0;
         if (m > FULL_SCALE) m = FULL_SCALE;
         if (r[31] || m == FULL_SCALE) begin
            neg_wide = 25'h100_0000 - 25'(m);
            smp = neg_wide[SAMPLE_W-1:0];
         end else begin
            smp = m[SAMPLE_W-1:0];
         end
      end
      last_mag[ch] = smp[SAMPLE_W-1] ? (16777216 - int'(smp)) : int'(smp);
   endtask

   // Mostly whole frames in channel order; now and then a flush with junk
   // fields, a stray sample on any channel, or a frame cut short
   task automatic queue_random_items(input int count);
      int done;
      int stop;
      logic [CH_COUNT_W-1:0] nch;
      logic [SAMPLE_W-1:0] s;
      logic [31:0] r;
      done = 0;
      while (done < count) begin
         r = $urandom;
         case ($urandom_range(0, 19))
            0: begin
               push_item(MODE_FLUSH, r[23:0], r[26:24]);
               done++;
            end
            1: begin
               make_sample(r[26:24], s);
               push_item(MODE_SAMPLE, s, r[26:24]);
               done++;
            end
            default: begin
               nch = active_channels();
               stop = int'(nch);
               if ($urandom_range(0, 15) == 0) stop = int'($urandom_range(0, stop - 1));
               for (int c = 0; c < stop; c++) begin
                  make_sample(3'(c), s);
                  push_item(MODE_SAMPLE, s, 3'(c));
                  done++;
               end
            end
         endcase
      end
   endtask

   // Hold until every item is taken and every report is in, then let the
   // block finish any close or trailing sample that yields no report
   task automatic wait_drained();
      while (items_accepted != items_queued || pending_reports.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   // Driver: present the next backlog item, hold it until taken, and
   // insert random idle bursts between items
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            update_window_stats(cur_item);
            items_accepted++;
            if (idle_on && $urandom_range(0, 5) == 0) send_gap = int'($urandom_range(1, 12));
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (sample_backlog.size() != 0) begin
               cur_item = sample_backlog.pop_front();
               req_tdata <= {5'd0, cur_item.channel, cur_item.sample};
               req_tuser <= cur_item.mode;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: take reports with random stalls, compare each with the
   // oldest expected report, field by field
   always @(posedge clock) begin
      window_report_type got;
      window_report_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[297:0];
            if (pending_reports.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: unexpected report, expected none actual %0h", $time, got);
            end else begin
               want = pending_reports.pop_front();
               reports_checked++;
               check_field("mean square", 64'(want.window_mean_square),
                           64'(got.window_mean_square));
               check_field("peak", 64'(want.peak_mag), 64'(got.peak_mag));
               check_field("frames", 64'(want.window_frames), 64'(got.window_frames));
               check_field("active flag", 64'(want.window_active), 64'(got.window_active));
               check_field("clip flag", 64'(want.clip_seen), 64'(got.clip_seen));
               check_field("near-full count", 64'(want.near_full_count),
                           64'(got.near_full_count));
               check_field("plateau count", 64'(want.plateau_count), 64'(got.plateau_count));
               check_field("sample count", 64'(want.sample_count), 64'(got.sample_count));
               check_field("active window count", 64'(want.active_count),
                           64'(got.active_count));
               check_field("clipped window count", 64'(want.clipped_count),
                           64'(got.clipped_count));
            end
         end
         if (recv_gap != 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0) recv_gap = int'($urandom_range(1, 12));
         end
      end
   end

   // Watchdog: end the run if the block stops making progress
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d of %0d items taken, %0d reports outstanding",
                  $time, items_accepted, items_queued, pending_reports.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      logic [FRAME_W-1:0] ws;
      logic [CH_COUNT_W-1:0] cc;
      logic [MAG_W-1:0] nf;
      logic [MAG_W-1:0] clip;
      logic [MAG_W-1:0] tol;
      logic [MS_W-1:0] act;
      logic [31:0] r;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         hist_mag[i] = '0;
         hist_near[i] = 1'b0;
         last_mag[i] = 0;
      end
      // Hold reset once, at the start
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset settings (two channels, long window).
      // Flush before any frame: no report. Junk fields on the flush.
      push_item(MODE_FLUSH, 24'hFFFFFF, 3'd7);
      // Full scale both polarities, each near full and clipping
      push_item(MODE_SAMPLE, 24'h7FFFFF, 3'd0);
      push_item(MODE_SAMPLE, 24'h800000, 3'd1);
      // Plateau on channel 0 (change within tolerance), none on channel 1
      push_item(MODE_SAMPLE, 24'(8388500), 3'd0);
      push_item(MODE_SAMPLE, 24'(-8388000), 3'd1);
      // Channel above the frame's last one: counted, never ends a frame
      push_item(MODE_SAMPLE, 24'h000001, 3'd5);
      // Partial frame, then flush: its sample joins the window, not the frames
      push_item(MODE_SAMPLE, 24'h000000, 3'd0);
      push_item(MODE_FLUSH, 24'h5A5A5A, 3'd2);
      // Second flush right after a close: empty window, no report
      push_item(MODE_FLUSH, 24'h000000, 3'd0);
      wait_drained();

      // Window size and channel count of zero act as one; every sample is
      // near full; the mean square overflows 47 bits and saturates
      write_settings(17'd0, 4'd0, 24'd0, 24'(FULL_SCALE), 24'd0, MS_MAX);
      push_item(MODE_SAMPLE, 24'h800000, 3'd3);
      push_item(MODE_SAMPLE, 24'h800000, 3'd0);
      push_item(MODE_SAMPLE, 24'h000000, 3'd0);
      push_item(MODE_SAMPLE, 24'h000000, 3'd0);
      wait_drained();

      // Channel count above the max acts as eight; one full frame per window;
      // every sample clips, any nonzero mean square is active
      write_settings(17'd1, 4'd15, 24'(FULL_SCALE), 24'd0, 24'(FULL_SCALE), 47'd0);
      push_item(MODE_SAMPLE, 24'h000001, 3'd0);
      push_item(MODE_SAMPLE, 24'hFFFFFF, 3'd1);
      push_item(MODE_SAMPLE, 24'h400000, 3'd2);
      push_item(MODE_SAMPLE, 24'h800000, 3'd3);
      push_item(MODE_SAMPLE, 24'h7FFFFF, 3'd4);
      push_item(MODE_SAMPLE, 24'hC00000, 3'd5);
      push_item(MODE_SAMPLE, 24'h000000, 3'd6);
      push_item(MODE_SAMPLE, 24'h123456, 3'd7);
      wait_drained();

      // Random phases. Each ends with the sender paused until every report
      // is in, so registers change only while the block is idle.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         r = $urandom;
         case ($urandom_range(0, 7))
            0: ws = 17'd0;
            1: ws = 17'd1;
            2, 3, 4: ws = 17'($urandom_range(2, 8));
            5: ws = 17'($urandom_range(9, 40));
            6: ws = 17'd65536;
            default: ws = 17'h1FFFF;
         endcase
         if ($urandom_range(0, 3) == 0) cc = 4'($urandom_range(0, 15));
         else cc = 4'($urandom_range(1, 8));
         case ($urandom_range(0, 3))
            0: nf = 24'(FULL_SCALE);
            1: nf = 24'd0;
            default: nf = 24'($urandom_range(4194304, FULL_SCALE));
         endcase
         case ($urandom_range(0, 3))
            0: clip = 24'(FULL_SCALE);
            1: clip = 24'd0;
            default: clip = 24'($urandom_range(4194304, FULL_SCALE));
         endcase
         case ($urandom_range(0, 3))
            0: tol = 24'd0;
            1: tol = 24'(FULL_SCALE);
            default: tol = 24'($urandom_range(0, 2000));
         endcase
         case ($urandom_range(0, 4))
            0: act = 47'd0;
            1: act = MS_MAX;
            2: act = 47'($urandom_range(0, 1 << 20));
            default: act = {r[14:0], $urandom};
         endcase
         // Widest frame and longest practical window first (flushes close
         // it), then a window of one frame, which cuts the open window short
         // at the next frame end
         if (phase == 0) begin
            ws = 17'd65536;
            cc = 4'd8;
         end else if (phase == 1) begin
            ws = 17'd1;
            cc = 4'd1;
         end
         write_settings(ws, cc, nf, clip, tol, act);
         // No idling at all in the last phase, random elsewhere
         idle_on = (phase != RANDOM_PHASES - 1) && ($urandom_range(0, 4) != 0);
         queue_random_items(ITEMS_PER_PHASE);
         wait_drained();
      end

      $display("Covered %0d items (%0d flushes) under %0d register settings;",
               items_accepted, flushes_queued, settings_used + 1);
      $display("%0d window reports compared field by field.", reports_checked);
      if (fail_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

### sim.f
rtl/acws_pkg.sv
rtl/acws_div.sv
rtl/acws_ctrl.sv
rtl/acws_datapath.sv
rtl/audio_clip_window_stats_core.sv
tb/sv/audio_clip_window_stats_core_test.sv
